// File: hdl/msort_pkg.sv
// ---------------------------------------------------------------------------
// msort_pkg
// Shared types and constants for the batch merge sorter.
// ---------------------------------------------------------------------------
`default_nettype none

package msort_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     batch_end;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     run_end;
    logic                     overflow;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/msort_ram.sv
// ---------------------------------------------------------------------------
// msort_ram
// Element buffer with one write port and two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module msort_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [msort_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]                raddr_a,
  input  wire logic [AW-1:0]                raddr_b,
  output logic      [msort_pkg::DATA_W-1:0] rdata_a,
  output logic      [msort_pkg::DATA_W-1:0] rdata_b
);
  import msort_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: hdl/merge_sorter.sv
// ---------------------------------------------------------------------------
// merge_sorter
// Collects a batch of signed values and returns them in stable ascending order.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_stall      item_t (value, batch_end)
// result    out        result_valid / result_stall  result_t (sorted_value,
//                                                     run_end, overflow)
//
// Items are written into the first buffer while loading. On the final item
// the batch of n values is merged bottom-up between two ping-pong buffers,
// one element per cycle, a rate set by the single write port of each buffer.
// Results then leave at one per cycle while result_stall is low. No item is
// taken while a batch is sorting or emitting. Reset clears the fill count
// and the dropped flag; the buffers need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module merge_sorter #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire msort_pkg::item_t   item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output msort_pkg::result_t      result
);
  import msort_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 2;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     fill, fill_next;
  logic              dropped, dropped_next;
  logic              src_sel, src_sel_next;
  logic [CW-1:0]     width, width_next;
  logic [CW-1:0]     i_idx, i_idx_next;
  logic [CW-1:0]     j_idx, j_idx_next;
  logic [CW-1:0]     mid, mid_next;
  logic [CW-1:0]     hi, hi_next;
  logic [CW-1:0]     k_idx, k_idx_next;
  logic [CW-1:0]     rk, rk_next;
  logic              out_valid, out_valid_next;
  result_t           out_q, out_next;

  logic              we0, we1;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     ra_l, ra_r;
  logic [DATA_W-1:0] rd0_l, rd0_r, rd1_l, rd1_r;
  logic [DATA_W-1:0] head_l, head_r;
  logic              take_l;
  logic [CW-1:0]     k_inc;
  logic [CW-1:0]     rk_inc;
  logic [SW-1:0]     width2;
  logic              item_fire;

  function automatic logic [CW-1:0] clamp(input logic [SW-1:0] a, input logic [CW-1:0] lim);
    return (a > SW'(lim)) ? lim : a[CW-1:0];
  endfunction

  msort_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_buf0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra_l),
    .raddr_b (ra_r),
    .rdata_a (rd0_l),
    .rdata_b (rd0_r)
  );

  msort_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_buf1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra_l),
    .raddr_b (ra_r),
    .rdata_a (rd1_l),
    .rdata_b (rd1_r)
  );

  assign item_stall   = (state != ST_LOAD);
  assign item_fire    = item_valid && !item_stall;
  assign result_valid = out_valid;
  assign result       = out_q;

  // Read data always reflects the current run heads, since the addresses
  // presented to the buffers are the next values of the head indexes.
  assign head_l = src_sel ? rd1_l : rd0_l;
  assign head_r = src_sel ? rd1_r : rd0_r;
  assign take_l = (i_idx < mid) &&
                  ((j_idx >= hi) || ($signed(head_l) <= $signed(head_r)));
  assign k_inc  = k_idx + CW'(1);
  assign rk_inc = rk + CW'(1);
  assign width2 = SW'(width) << 1;

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    dropped_next   = dropped;
    src_sel_next   = src_sel;
    width_next     = width;
    i_idx_next     = i_idx;
    j_idx_next     = j_idx;
    mid_next       = mid;
    hi_next        = hi;
    k_idx_next     = k_idx;
    rk_next        = rk;
    out_valid_next = out_valid && result_stall;
    out_next       = out_q;
    we0            = 1'b0;
    we1            = 1'b0;
    waddr          = k_idx[AW-1:0];
    wdata          = take_l ? head_l : head_r;

    unique case (state)
      ST_LOAD: begin
        if (item_fire) begin
          if (fill < CW'(MAX_ITEMS)) begin
            we0       = 1'b1;
            waddr     = fill[AW-1:0];
            wdata     = item.value;
            fill_next = fill + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (item.batch_end) begin
            src_sel_next = 1'b0;
            width_next   = CW'(1);
            k_idx_next   = '0;
            i_idx_next   = '0;
            mid_next     = clamp(SW'(1), fill_next);
            hi_next      = clamp(SW'(2), fill_next);
            j_idx_next   = clamp(SW'(1), fill_next);
            rk_next      = '0;
            state_next   = (fill_next > CW'(1)) ? ST_SORT : ST_EMIT;
          end
        end
      end

      ST_SORT: begin
        // The merged element goes to the buffer that is not being read.
        we0        = src_sel;
        we1        = ~src_sel;
        k_idx_next = k_inc;
        if (take_l) begin
          i_idx_next = i_idx + CW'(1);
        end else begin
          j_idx_next = j_idx + CW'(1);
        end
        if (k_inc == hi) begin
          if (hi == fill) begin
            // End of a pass: swap buffers and double the run width.
            src_sel_next = ~src_sel;
            width_next   = width2[CW-1:0];
            k_idx_next   = '0;
            i_idx_next   = '0;
            mid_next     = clamp(width2, fill);
            hi_next      = clamp(width2 << 1, fill);
            j_idx_next   = clamp(width2, fill);
            if (width2 >= SW'(fill)) begin
              rk_next    = '0;
              state_next = ST_EMIT;
            end
          end else begin
            i_idx_next = hi;
            mid_next   = clamp(SW'(hi) + SW'(width), fill);
            hi_next    = clamp(SW'(hi) + width2, fill);
            j_idx_next = clamp(SW'(hi) + SW'(width), fill);
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid || !result_stall) begin
          out_valid_next        = 1'b1;
          out_next.sorted_value = head_l;
          out_next.run_end      = (rk_inc == fill);
          out_next.overflow     = dropped;
          rk_next               = rk_inc;
          if (rk_inc == fill) begin
            fill_next    = '0;
            dropped_next = 1'b0;
            state_next   = ST_LOAD;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase

    ra_l = (state_next == ST_EMIT) ? rk_next[AW-1:0] : i_idx_next[AW-1:0];
    ra_r = j_idx_next[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      fill      <= '0;
      dropped   <= 1'b0;
      src_sel   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      dropped   <= dropped_next;
      src_sel   <= src_sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    width <= width_next;
    i_idx <= i_idx_next;
    j_idx <= j_idx_next;
    mid   <= mid_next;
    hi    <= hi_next;
    k_idx <= k_idx_next;
    rk    <= rk_next;
    out_q <= out_next;
  end

endmodule

`default_nettype wire
